// ===== rtl/core/ikht_pkg.sv =====
// Shared widths, opcodes, status codes and control types of the integer key hash table.
// Used by the channel interfaces, the microcode sequencer and the top level.
package ikht_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int KEY_W       = 31;
  localparam int REC_W       = 5;
  localparam int PROBE_W     = SLOT_W + 1;
  localparam int COUNT_W     = SLOT_W + 1;
  localparam int SQ_W        = 2 * SLOT_W;
  localparam int MAX_PROBES  = 2 * (TABLE_SLOTS - 1);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic accept;
    logic no_probe;
    logic settled;
    logic out_full;
  } flags_t;

  typedef struct packed {
    logic take;
    logic advance;
    logic finish;
  } ctrl_t;

endpackage

// ===== rtl/core/ikht_if.sv =====
// Valid/ready channel interfaces for request and response items of the hash table.
// Depends on ikht_pkg for the field widths.
interface ikht_in_if;
  import ikht_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [KEY_W-1:0]   key;
  logic [REC_W-1:0]   record_ref;
  modport source(output valid, opcode, key, record_ref, input ready);
  modport sink(input valid, opcode, key, record_ref, output ready);
endinterface

interface ikht_out_if;
  import ikht_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [SLOT_W-1:0]  slot;
  logic [PROBE_W-1:0] probes;
  logic [REC_W-1:0]   found_record;
  logic [COUNT_W-1:0] stored_total;
  modport source(output valid, status, slot, probes, found_record, stored_total, input ready);
  modport sink(input valid, status, slot, probes, found_record, stored_total, output ready);
endinterface

// ===== rtl/core/ikht_sequencer.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on ikht_pkg for the flag and control word types.
module ikht_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  ikht_pkg::flags_t flags,
  output ikht_pkg::ctrl_t  ctrl
);
  import ikht_pkg::*;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_ACCEPT   = 3'd1,
    COND_NO_PROBE = 3'd2,
    COND_SETTLED  = 3'd3,
    COND_OUT_FULL = 3'd4
  } cond_t;

  typedef logic [2:0] upc_t;

  typedef struct packed {
    ctrl_t ctl;
    cond_t cond;
    upc_t  jump;
    upc_t  next;
  } uword_t;

  localparam upc_t U_FETCH    = 3'd0;
  localparam upc_t U_DISPATCH = 3'd1;
  localparam upc_t U_EVAL     = 3'd2;
  localparam upc_t U_ADVANCE  = 3'd3;
  localparam upc_t U_RESULT   = 3'd4;

  function automatic uword_t rom(input upc_t a);
    uword_t w;
    case (a)
      U_DISPATCH: w = '{ctl: '{take: 1'b0, advance: 1'b0, finish: 1'b0},
                         cond: COND_NO_PROBE, jump: U_RESULT, next: U_EVAL};
      U_EVAL:     w = '{ctl: '{take: 1'b0, advance: 1'b0, finish: 1'b0},
                         cond: COND_SETTLED, jump: U_RESULT, next: U_ADVANCE};
      U_ADVANCE:  w = '{ctl: '{take: 1'b0, advance: 1'b1, finish: 1'b0},
                         cond: COND_ALWAYS, jump: U_EVAL, next: U_EVAL};
      U_RESULT:   w = '{ctl: '{take: 1'b0, advance: 1'b0, finish: 1'b1},
                         cond: COND_OUT_FULL, jump: U_RESULT, next: U_FETCH};
      default:    w = '{ctl: '{take: 1'b1, advance: 1'b0, finish: 1'b0},
                         cond: COND_ACCEPT, jump: U_DISPATCH, next: U_FETCH};
    endcase
    return w;
  endfunction

  upc_t   pc;
  upc_t   pc_next;
  uword_t word;
  logic   taken;

  always_comb begin
    word = rom(pc);
    case (word.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_ACCEPT:   taken = flags.accept;
      COND_NO_PROBE: taken = flags.no_probe;
      COND_SETTLED:  taken = flags.settled;
      COND_OUT_FULL: taken = flags.out_full;
      default:       taken = 1'b0;
    endcase
    pc_next = taken ? word.jump : word.next;
    ctrl    = word.ctl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= U_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/core/int_key_hash_table_quadratic_probe_unit.sv =====
// Open-addressing hash table with quadratic probing; clear, insert and search items.
// Results are registered in the result step, after dispatch and any evaluate/advance probe
// steps; clear and the unused opcode skip probing. A search or insert takes at most 126 probe
// steps (collisions plus skipped minus steps). One item is in work at a time, paced by the
// two-step probe loop; the result step holds while an earlier response waits. Reset clears the
// slot flags and the entry count; key and record memories are left unset, with no clearing pass.
module int_key_hash_table_quadratic_probe_unit (
  input logic        clk,
  input logic        rst,
  ikht_in_if.sink    req,
  ikht_out_if.source rsp
);
  import ikht_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  logic [1:0]         op;
  logic [KEY_W-1:0]   key;
  logic [REC_W-1:0]   rec;
  logic [PROBE_W-1:0] cnt;
  logic [SLOT_W-1:0]  pos;
  logic               pending;

  logic [TABLE_SLOTS-1:0] slot_used;
  logic [KEY_W-1:0]       slot_key [TABLE_SLOTS];
  logic [REC_W-1:0]       slot_rec [TABLE_SLOTS];
  logic [COUNT_W-1:0]     entry_count;

  logic               rd_used;
  logic [KEY_W-1:0]   rd_key;
  logic [REC_W-1:0]   rd_rec;

  logic [SLOT_W-1:0]  home;
  logic [SLOT_W-1:0]  step;
  logic [SQ_W-1:0]    sq;
  logic [SLOT_W-1:0]  adv_pos;
  logic               adv_hit;
  logic [SLOT_W-1:0]  rd_addr;
  logic               rd_en;
  logic               req_accept;
  logic               out_full;
  logic               finish_en;
  logic               ins_ok;
  logic               hit;
  logic               probe_ok;
  logic               exhausted;

  ikht_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign req.ready  = ctrl.take;
  assign req_accept = req.valid && ctrl.take;
  assign out_full   = rsp.valid && !rsp.ready;
  assign finish_en  = ctrl.finish && !out_full;

  assign home = key[SLOT_W-1:0];
  assign step = cnt[PROBE_W-1:1] + SLOT_W'(1);
  assign sq   = SQ_W'(step) * SQ_W'(step);

  always_comb begin
    adv_hit = 1'b1;
    adv_pos = pos;
    if (!cnt[0]) begin
      adv_pos = home + sq[SLOT_W-1:0];
    end else if (sq <= SQ_W'(home)) begin
      adv_pos = home - sq[SLOT_W-1:0];
    end else if (sq[SLOT_W-1:0] == home) begin
      adv_pos = '0;
    end else begin
      adv_hit = 1'b0;
    end
  end

  assign rd_addr = ctrl.take ? req.key[SLOT_W-1:0] : adv_pos;
  assign rd_en   = req_accept || ctrl.advance;

  assign ins_ok    = (op == OP_INSERT) && pending && !rd_used;
  assign hit       = (op == OP_SEARCH) && pending && rd_used && (rd_key == key);
  assign probe_ok  = pending && (!rd_used || ((op == OP_SEARCH) && (rd_key == key)));
  assign exhausted = cnt >= PROBE_W'(MAX_PROBES);

  assign flags.accept   = req_accept;
  assign flags.no_probe = (op == OP_CLEAR) || (op == OP_UNUSED);
  assign flags.settled  = probe_ok || exhausted;
  assign flags.out_full = out_full;

  always_ff @(posedge clk) begin
    if (req_accept) begin
      op  <= req.opcode;
      key <= req.key;
      rec <= req.record_ref;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      pos     <= '0;
      pending <= 1'b0;
    end else if (req_accept) begin
      cnt     <= '0;
      pos     <= req.key[SLOT_W-1:0];
      pending <= 1'b1;
    end else if (ctrl.advance) begin
      cnt     <= cnt + PROBE_W'(1);
      pending <= adv_hit;
      if (adv_hit) begin
        pos <= adv_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish_en && ins_ok) begin
      slot_key[pos] <= key;
      slot_rec[pos] <= rec;
    end
    if (rd_en) begin
      rd_key  <= slot_key[rd_addr];
      rd_rec  <= slot_rec[rd_addr];
      rd_used <= slot_used[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used   <= '0;
      entry_count <= '0;
    end else if (finish_en) begin
      if (op == OP_CLEAR) begin
        slot_used   <= '0;
        entry_count <= '0;
      end else if (ins_ok) begin
        slot_used[pos] <= 1'b1;
        entry_count    <= entry_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish_en) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_en) begin
      rsp.slot         <= '0;
      rsp.probes       <= cnt;
      rsp.found_record <= '0;
      rsp.stored_total <= entry_count;
      case (op)
        OP_CLEAR: begin
          rsp.status       <= ST_DONE;
          rsp.probes       <= '0;
          rsp.stored_total <= '0;
        end
        OP_INSERT: begin
          if (ins_ok) begin
            rsp.status       <= ST_DONE;
            rsp.slot         <= pos;
            rsp.found_record <= rec;
            rsp.stored_total <= entry_count + COUNT_W'(1);
          end else begin
            rsp.status <= ST_FULL;
          end
        end
        OP_SEARCH: begin
          if (hit) begin
            rsp.status       <= ST_FOUND;
            rsp.slot         <= pos;
            rsp.found_record <= rd_rec;
          end else begin
            rsp.status <= ST_MISS;
          end
        end
        default: begin
          rsp.status <= ST_MISS;
          rsp.probes <= '0;
        end
      endcase
    end
  end

  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    entry_count == COUNT_W'($countones(slot_used)))
    else $error("entry count differs from the number of used slots");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= PROBE_W'(MAX_PROBES))
    else $error("probe count ran past the end of the sequence");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> !ctrl.take)
    else $error("request taken while an item is still in work");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(ctrl.finish))
    else $error("response raised outside the result step");

endmodule

// ===== verif/tb_int_key_hash_table_quadratic_probe_unit.sv =====
// Self-checking testbench for the quadratic-probe hash table: random and directed clear,
// insert, search and unused-opcode requests, checked by an internal table predictor.
// Depends on ikht_pkg, the ikht_in_if/ikht_out_if interfaces and the hash table top level.
module tb_int_key_hash_table_quadratic_probe_unit;
  import ikht_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;

  typedef enum logic [1:0] {PACE_FULL, PACE_SLOW_SRC, PACE_SLOW_SINK, PACE_BOTH} pace_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] record_ref;
    pace_e            pace;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [PROBE_W-1:0] probes;
    logic [REC_W-1:0]   found_record;
    logic [COUNT_W-1:0] stored_total;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;

  ikht_in_if  req();
  ikht_out_if rsp();

  int_key_hash_table_quadratic_probe_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  request_t    request_backlog[$];
  outcome_t    expected_outcomes[$];
  logic        took_req = 1'b0;
  pace_e       cur_pace = PACE_FULL;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  bit               slot_taken[TABLE_SLOTS];
  logic [KEY_W-1:0] slot_keys[TABLE_SLOTS];
  logic [REC_W-1:0] slot_recs[TABLE_SLOTS];
  int unsigned      entries_held = 0;

  function automatic bit probe_next(input int unsigned home, inout int unsigned cnt,
                                    inout int unsigned pos);
    int unsigned step;
    int unsigned sq;
    bit hit;
    hit = 1'b0;
    step = cnt / 2 + 1;
    while (!hit && step < TABLE_SLOTS) begin
      sq = step * step;
      if (cnt % 2 == 0) begin
        cnt = cnt + 1;
        pos = (home + sq) % TABLE_SLOTS;
        hit = 1'b1;
      end else begin
        cnt = cnt + 1;
        if (sq <= home) begin
          pos = home - sq;
          hit = 1'b1;
        end else if ((sq - home) % TABLE_SLOTS == 0) begin
          pos = 0;
          hit = 1'b1;
        end else begin
          step = cnt / 2 + 1;
        end
      end
    end
    return hit;
  endfunction

  function automatic outcome_t table_access_outcome(request_t r);
    outcome_t o;
    int unsigned home;
    int unsigned cnt;
    int unsigned pos;
    bit ok;
    o = '0;
    o.status = ST_MISS;
    home = 32'(r.key[SLOT_W-1:0]);
    cnt = 0;
    pos = home;
    ok = 1'b1;
    case (r.opcode)
      OP_CLEAR: begin
        for (int i = 0; i < TABLE_SLOTS; i++) slot_taken[i] = 1'b0;
        entries_held = 0;
        o.status = ST_DONE;
      end
      OP_INSERT: begin
        while (ok && slot_taken[pos]) ok = probe_next(home, cnt, pos);
        if (ok) begin
          slot_taken[pos] = 1'b1;
          slot_keys[pos] = r.key;
          slot_recs[pos] = r.record_ref;
          entries_held = entries_held + 1;
          o.status = ST_DONE;
          o.slot = SLOT_W'(pos);
          o.found_record = r.record_ref;
        end else begin
          o.status = ST_FULL;
        end
      end
      OP_SEARCH: begin
        while (ok && slot_taken[pos] && slot_keys[pos] != r.key) ok = probe_next(home, cnt, pos);
        if (ok && slot_taken[pos] && slot_keys[pos] == r.key) begin
          o.status = ST_FOUND;
          o.slot = SLOT_W'(pos);
          o.found_record = slot_recs[pos];
        end
      end
      default: begin
      end
    endcase
    o.probes = PROBE_W'(cnt);
    o.stored_total = COUNT_W'(entries_held);
    return o;
  endfunction

  function automatic int unsigned src_gap_pct(pace_e p);
    case (p)
      PACE_SLOW_SRC: return 80;
      PACE_BOTH:     return 26;
      default:       return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct(pace_e p);
    case (p)
      PACE_SLOW_SINK: return 80;
      PACE_BOTH:      return 26;
      default:        return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", n_results, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic add_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
                             input logic [REC_W-1:0] rec);
    request_t r;
    int unsigned phase;
    phase = request_backlog.size() * 4 / ITEM_TARGET;
    if (phase > 3) phase = 3;
    r.opcode = op;
    r.key = k;
    r.record_ref = rec;
    r.pace = pace_e'(phase);
    request_backlog.push_back(r);
  endtask

  // Request driver: a new transfer is offered once the previous one has been taken.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || took_req) begin
      if (request_backlog.size() != 0 &&
          $urandom_range(99, 0) >= src_gap_pct(request_backlog[0].pace)) begin
        nxt = request_backlog.pop_front();
        req.valid <= 1'b1;
        req.opcode <= nxt.opcode;
        req.key <= nxt.key;
        req.record_ref <= nxt.record_ref;
        cur_pace <= nxt.pace;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // One long hold-off of the response side, so that the request side backs up.
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted == 40) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= sink_stall_pct(cur_pace));
    end
  end

  always @(posedge clk) begin : observe
    outcome_t want;
    if (rst) begin
      took_req <= 1'b0;
    end else begin
      took_req <= req.valid && req.ready;
      if (rsp.valid && rsp.ready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", 32'(rsp.status), 32'(want.status));
          check_field("slot", 32'(rsp.slot), 32'(want.slot));
          check_field("probes", 32'(rsp.probes), 32'(want.probes));
          check_field("found_record", 32'(rsp.found_record), 32'(want.found_record));
          check_field("stored_total", 32'(rsp.stored_total), 32'(want.stored_total));
        end
        n_results++;
      end
      if (req.valid && req.ready) begin
        expected_outcomes.push_back(table_access_outcome(
            '{opcode: req.opcode, key: req.key, record_ref: req.record_ref, pace: PACE_FULL}));
        n_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SLOT_W-1:0] homes[4];
    logic [KEY_W-1:0]  inserted[$];
    logic [KEY_W-1:0]  k;
    logic [SLOT_W-1:0] h;
    int unsigned nhomes;
    int unsigned target;
    int unsigned done;
    int unsigned roll;
    rst = 1'b1;
    req.valid = 1'b0;
    req.opcode = OP_CLEAR;
    req.key = '0;
    req.record_ref = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) slot_taken[i] = 1'b0;

    // Directed: empty table, unused opcode, extreme keys and records, collisions on
    // the home slot, a duplicate key, a search miss after probing, and a clear.
    add_request(OP_SEARCH, 31'd5, 5'd0);
    add_request(OP_UNUSED, 31'h7FFFFFFF, 5'd31);
    add_request(OP_INSERT, 31'd0, 5'd0);
    add_request(OP_INSERT, 31'h7FFFFFFF, 5'd31);
    add_request(OP_INSERT, 31'd64, 5'd1);
    add_request(OP_INSERT, 31'd128, 5'd2);
    add_request(OP_INSERT, 31'd0, 5'd3);
    add_request(OP_SEARCH, 31'd0, 5'd31);
    add_request(OP_SEARCH, 31'd128, 5'd0);
    add_request(OP_SEARCH, 31'h7FFFFFFF, 5'd0);
    add_request(OP_SEARCH, 31'h7FFFFFBF, 5'd0);
    add_request(OP_INSERT, 31'h7FFFFFBF, 5'd17);
    add_request(OP_SEARCH, 31'h7FFFFFBF, 5'd0);
    add_request(OP_INSERT, 31'd36, 5'd10);
    add_request(OP_INSERT, 31'd100, 5'd11);
    add_request(OP_CLEAR, 31'h2AAAAAAA, 5'd21);
    add_request(OP_SEARCH, 31'd0, 5'd0);
    add_request(OP_INSERT, 31'h55555555, 5'd10);
    add_request(OP_SEARCH, 31'h55555555, 5'd0);

    // Random episodes: mostly collision-heavy fills with searches of stored keys,
    // some of them running the table to full, plus misses, stray opcodes and clears.
    while (request_backlog.size() < ITEM_TARGET) begin
      if ($urandom_range(4, 0) != 0) begin
        add_request(OP_CLEAR, KEY_W'($urandom()), REC_W'($urandom()));
      end
      nhomes = $urandom_range(4, 1);
      for (int j = 0; j < 4; j++) begin
        case ($urandom_range(3, 0))
          0:       homes[j] = 6'd0;
          1:       homes[j] = 6'd36;
          2:       homes[j] = 6'd63;
          default: homes[j] = SLOT_W'($urandom());
        endcase
      end
      target = ($urandom_range(3, 0) == 0) ? $urandom_range(90, 66) : $urandom_range(40, 1);
      inserted.delete();
      done = 0;
      while (done < target) begin
        roll = $urandom_range(99, 0);
        h = ($urandom_range(4, 0) != 0) ? homes[$urandom_range(nhomes - 1, 0)]
                                        : SLOT_W'($urandom());
        k = {(KEY_W - SLOT_W)'($urandom()), h};
        if (roll < 55) begin
          add_request(OP_INSERT, k, REC_W'($urandom()));
          inserted.push_back(k);
          done++;
        end else if (roll < 85 && inserted.size() != 0) begin
          add_request(OP_SEARCH, inserted[$urandom_range(inserted.size() - 1, 0)],
                      REC_W'($urandom()));
        end else if (roll < 96) begin
          add_request(OP_SEARCH, k, REC_W'($urandom()));
        end else if (roll < 99) begin
          add_request(OP_UNUSED, KEY_W'($urandom()), REC_W'($urandom()));
        end else begin
          add_request(OP_CLEAR, KEY_W'($urandom()), REC_W'($urandom()));
        end
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || req.valid || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== int_key_hash_table_quadratic_probe_unit.f =====
rtl/core/ikht_pkg.sv
rtl/core/ikht_if.sv
rtl/core/ikht_sequencer.sv
rtl/core/int_key_hash_table_quadratic_probe_unit.sv
verif/tb_int_key_hash_table_quadratic_probe_unit.sv
